// File: rtl/uer_pkg.sv
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// phase and status codes, register indexes, field widths; no dependencies

package uer_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int TRIG_W    = 8;
  localparam int TIMEOUT_W = 17;
  localparam int TPC_W     = 6;
  localparam int DIST_W    = 10;
  localparam int COOL_W    = 16;

  localparam logic [DIST_W-1:0] CM_SAT = 10'd1023;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_WAIT = 3'd2,
    PH_MEAS = 3'd3,
    PH_COOL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSENSOR = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_TRIGGER  = 3'd0,
    REG_TIMEOUT  = 3'd1,
    REG_TPC      = 3'd2,
    REG_MAX_DIST = 3'd3,
    REG_COOLDOWN = 3'd4
  } reg_idx_t;

endpackage

// File: rtl/ultrasonic_echo_ranger_unit.sv
// ultrasonic_echo_ranger_unit: trigger, echo wait, echo width timing and cooldown
// one timer tick per request; depends on uer_pkg
//
//   channel  | direction | handshake           | payload
//   in_      | slave     | tvalid/tready       | tdata: start_req, echo
//   out_     | master     | tvalid/tready       | tdata: trigger, busy, done, status, distance
//   cfg_     | apb slave | psel/penable/pready | 5 registers at byte address 4*i
//
// one request per cycle while the output is not stalled, one result per request:
// the phase machine and counters advance once per accepted tick, the result
// lands in the output register. a stalled output holds in_tready low only
// while the output register is full and not taken. synchronous reset puts the
// registers at their defaults and the phase at idle; no clearing pass.

module ultrasonic_echo_ranger_unit #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] start_req, [1] echo, [7:2] zero
  input  logic [uer_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] trigger, [1] busy_res, [2] done_res, [4:3] status, [14:5] distance_cm, [15] zero
  output logic [uer_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [uer_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import uer_pkg::*;

  localparam int CNT_W = (TIMER_BITS + 1 > COOL_W) ? TIMER_BITS + 1 : COOL_W;
  localparam int CMP_W = (TIMER_BITS + 1 > TIMEOUT_W) ? TIMER_BITS + 1 : TIMEOUT_W;

  // configuration registers
  logic [TRIG_W-1:0]    trigger_ticks_r;
  logic [TIMEOUT_W-1:0] timeout_ticks_r;
  logic [TPC_W-1:0]     ticks_per_cm_r;
  logic [DIST_W-1:0]    max_distance_r;
  logic [COOL_W-1:0]    cooldown_ticks_r;

  // measurement state
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  tick_r, tick_nxt;
  logic [TPC_W-1:0]  sub_r, sub_nxt;
  logic [DIST_W-1:0] cm_r, cm_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              start, echo, in_acc, cfg_wr;
  logic [CMP_W-1:0]  tick_inc, tmo, cap, etick;
  logic [TRIG_W-1:0] tlen;
  logic [TPC_W-1:0]  per, esub_inc, esub;
  logic [DIST_W-1:0] ecm_base, ecm;
  logic              trig, busy, done;
  status_t           status;
  logic [DIST_W-1:0] dist_cm;

  assign start    = in_tdata[0];
  assign echo     = in_tdata[1];
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r  <= TRIG_W'(7);
      timeout_ticks_r  <= TIMEOUT_W'(65536);
      ticks_per_cm_r   <= TPC_W'(36);
      max_distance_r   <= DIST_W'(200);
      cooldown_ticks_r <= COOL_W'(25000);
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_TRIGGER:  trigger_ticks_r  <= cfg_pwdata[TRIG_W-1:0];
        REG_TIMEOUT:  timeout_ticks_r  <= cfg_pwdata[TIMEOUT_W-1:0];
        REG_TPC:      ticks_per_cm_r   <= cfg_pwdata[TPC_W-1:0];
        REG_MAX_DIST: max_distance_r   <= cfg_pwdata[DIST_W-1:0];
        REG_COOLDOWN: cooldown_ticks_r <= cfg_pwdata[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_TRIGGER:  cfg_prdata = CFG_DATA_W'(trigger_ticks_r);
      REG_TIMEOUT:  cfg_prdata = CFG_DATA_W'(timeout_ticks_r);
      REG_TPC:      cfg_prdata = CFG_DATA_W'(ticks_per_cm_r);
      REG_MAX_DIST: cfg_prdata = CFG_DATA_W'(max_distance_r);
      REG_COOLDOWN: cfg_prdata = CFG_DATA_W'(cooldown_ticks_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // shared counting terms
  always_comb begin
    cap      = CMP_W'(1) << TIMER_BITS;
    tmo      = (CMP_W'(timeout_ticks_r) > cap) ? cap : CMP_W'(timeout_ticks_r);
    tlen     = (trigger_ticks_r == '0) ? TRIG_W'(1) : trigger_ticks_r;
    per      = (ticks_per_cm_r == '0) ? TPC_W'(1) : ticks_per_cm_r;
    tick_inc = CMP_W'(tick_r) + CMP_W'(1);
    // first echo-high tick restarts the counters
    etick    = (phase_r == PH_WAIT) ? CMP_W'(1) : tick_inc;
    esub_inc = ((phase_r == PH_WAIT) ? TPC_W'(0) : sub_r) + TPC_W'(1);
    ecm_base = (phase_r == PH_WAIT) ? DIST_W'(0) : cm_r;
    if (esub_inc >= per) begin
      esub = '0;
      ecm  = (ecm_base < CM_SAT) ? ecm_base + DIST_W'(1) : ecm_base;
    end else begin
      esub = esub_inc;
      ecm  = ecm_base;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    sub_nxt   = sub_r;
    cm_nxt    = cm_r;
    case (phase_r)
      PH_TRIG: begin
        if (tick_inc >= CMP_W'(tlen)) begin
          tick_nxt  = '0;
          phase_nxt = PH_WAIT;
        end else begin
          tick_nxt = CNT_W'(tick_inc);
        end
      end
      PH_WAIT, PH_MEAS: begin
        if (echo) begin
          phase_nxt = PH_MEAS;
          tick_nxt  = CNT_W'(etick);
          sub_nxt   = esub;
          cm_nxt    = ecm;
          if (etick >= tmo) begin
            tick_nxt  = '0;
            phase_nxt = (cooldown_ticks_r == '0) ? PH_IDLE : PH_COOL;
          end
        end else if (phase_r == PH_WAIT) begin
          tick_nxt = CNT_W'(tick_inc);
          if (tick_inc >= tmo) begin
            tick_nxt  = '0;
            phase_nxt = (cooldown_ticks_r == '0) ? PH_IDLE : PH_COOL;
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = (cooldown_ticks_r == '0) ? PH_IDLE : PH_COOL;
        end
      end
      PH_COOL: begin
        if (tick_inc >= CMP_W'(cooldown_ticks_r)) begin
          tick_nxt  = '0;
          phase_nxt = PH_IDLE;
        end else begin
          tick_nxt = CNT_W'(tick_inc);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (start) begin
          if (tlen == TRIG_W'(1)) begin
            tick_nxt  = '0;
            phase_nxt = PH_WAIT;
          end else begin
            tick_nxt  = CNT_W'(1);
            phase_nxt = PH_TRIG;
          end
        end
      end
    endcase
  end

  // result fields
  always_comb begin
    trig    = 1'b0;
    busy    = 1'b1;
    done    = 1'b0;
    status  = ST_OK;
    dist_cm = '0;
    case (phase_r)
      PH_TRIG: trig = 1'b1;
      PH_WAIT, PH_MEAS: begin
        if (echo) begin
          if (etick >= tmo) begin
            done   = 1'b1;
            status = ST_RANGE;
          end
        end else if (phase_r == PH_WAIT) begin
          if (tick_inc >= tmo) begin
            done   = 1'b1;
            status = ST_NOSENSOR;
          end
        end else begin
          done = 1'b1;
          if (cm_r > max_distance_r) begin
            status = ST_RANGE;
          end else begin
            dist_cm = cm_r;
          end
        end
      end
      PH_COOL: ;
      default: begin
        busy = start;
        trig = start;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      sub_r       <= '0;
      cm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        sub_r       <= sub_nxt;
        cm_r        <= cm_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0, dist_cm, status, done, busy, trig};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/uer_checker.sv
// uer_checker: port-level checks for ultrasonic_echo_ranger_unit
// bound to the top level below; depends on uer_pkg

module uer_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [uer_pkg::OUT_DATA_W-1:0] out_tdata
);
  import uer_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // every accepted request yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

  // input only stalls behind a pending result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a pending result");

  // trigger and done ticks are always busy ticks
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[2]) |-> out_tdata[1])
    else $error("trigger or done without busy");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/tb.sv
// tb: stream-level test of ultrasonic_echo_ranger_unit, one tick request in, one result out
// predicts every result with a tick-accurate copy of the ranger state; depends on uer_pkg
// registers are changed over the cfg_ port only when no result is outstanding

module tb;
  import uer_pkg::*;

  localparam int TMO_CAP = 1 << TIMER_BITS_DEF;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 5'd28;

  typedef struct {
    logic trigger;
    logic busy;
    logic done;
    status_t status;
    logic [DIST_W-1:0] distance;
  } ranger_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  wire in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  wire out_tvalid;
  logic out_tready = 1'b0;
  wire [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  wire [CFG_DATA_W-1:0] cfg_prdata;
  wire cfg_pready;

  ultrasonic_echo_ranger_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copy
  logic [TRIG_W-1:0] trig_len_r = 8'd7;
  logic [TIMEOUT_W-1:0] tmo_r = 17'd65536;
  logic [TPC_W-1:0] tpc_r = 6'd36;
  logic [DIST_W-1:0] max_cm_r = 10'd200;
  logic [COOL_W-1:0] cool_r = 16'd25000;

  // ranger state copy
  phase_t ph = PH_IDLE;
  logic [TIMEOUT_W-1:0] tick_cnt = '0;
  logic [TPC_W-1:0] sub_cnt = '0;
  logic [DIST_W-1:0] cm_cnt = '0;

  logic [1:0] tick_q[$];  // {echo, start_req}
  ranger_res_t range_res_q[$];
  int ticks_queued = 0;
  int ticks_checked = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit in_hs = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  task automatic count_echo_tick();
    logic [TPC_W-1:0] per;
    per = (tpc_r == 0) ? 6'd1 : tpc_r;
    tick_cnt = tick_cnt + 1'b1;
    sub_cnt = sub_cnt + 1'b1;
    if (sub_cnt >= per) begin
      sub_cnt = '0;
      if (cm_cnt < CM_SAT) cm_cnt = cm_cnt + 1'b1;
    end
  endtask

  task automatic close_measure();
    tick_cnt = '0;
    ph = (cool_r == 0) ? PH_IDLE : PH_COOL;
  endtask

  task automatic ranger_tick(input logic start, input logic echo, output ranger_res_t r);
    logic [TIMEOUT_W-1:0] tmo;
    logic [TRIG_W-1:0] tlen;
    tmo = (tmo_r > TMO_CAP) ? 17'(TMO_CAP) : tmo_r;
    tlen = (trig_len_r == 0) ? 8'd1 : trig_len_r;
    r.trigger = 1'b0;
    r.busy = 1'b1;
    r.done = 1'b0;
    r.status = ST_OK;
    r.distance = '0;
    // the start tick is already the first trigger tick
    if (ph == PH_IDLE && start) begin
      tick_cnt = '0;
      ph = PH_TRIG;
    end
    case (ph)
      PH_IDLE: r.busy = 1'b0;
      PH_TRIG: begin
        r.trigger = 1'b1;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= tlen) begin
          tick_cnt = '0;
          ph = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          tick_cnt = '0;
          sub_cnt = '0;
          cm_cnt = '0;
          ph = PH_MEAS;
          count_echo_tick();
          if (tick_cnt >= tmo) begin
            r.done = 1'b1;
            r.status = ST_RANGE;
            close_measure();
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= tmo) begin
            r.done = 1'b1;
            r.status = ST_NOSENSOR;
            close_measure();
          end
        end
      end
      PH_MEAS: begin
        if (echo) begin
          count_echo_tick();
          if (tick_cnt >= tmo) begin
            r.done = 1'b1;
            r.status = ST_RANGE;
            close_measure();
          end
        end else begin
          r.done = 1'b1;
          if (cm_cnt > max_cm_r) begin
            r.status = ST_RANGE;
          end else begin
            r.distance = cm_cnt;
          end
          close_measure();
        end
      end
      default: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= {1'b0, cool_r}) begin
          tick_cnt = '0;
          ph = PH_IDLE;
        end
      end
    endcase
  endtask

  // request driver
  always @(negedge clk) begin
    if (!(in_tvalid && !in_hs)) begin
      if (in_gap == 0 && idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (rst_n && tick_q.size() != 0) begin
        in_tdata <= {6'd0, tick_q.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_gap == 0 && idle_on && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
    if (out_gap != 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: check accepted results, predict accepted requests
  always @(posedge clk) begin
    ranger_res_t want;
    ranger_res_t pred;
    in_hs = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (range_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = range_res_q.pop_front();
        ticks_checked++;
        if (out_tdata[0] !== want.trigger || out_tdata[1] !== want.busy ||
            out_tdata[2] !== want.done || out_tdata[4:3] !== want.status ||
            out_tdata[14:5] !== want.distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want trig %0b busy %0b done %0b st %0d dist %0d, %s",
                     want.trigger, want.busy, want.done, want.status, want.distance,
                     $sformatf("got trig %0b busy %0b done %0b st %0d dist %0d",
                               out_tdata[0], out_tdata[1], out_tdata[2],
                               out_tdata[4:3], out_tdata[14:5]));
        end
      end
    end
    if (in_hs) begin
      ranger_tick(in_tdata[0], in_tdata[1], pred);
      range_res_q.push_back(pred);
    end
  end

  task automatic push_tick(input logic start, input logic echo);
    tick_q.push_back({echo, start});
    ticks_queued++;
  endtask

  task automatic drain();
    while (ticks_checked != ticks_queued) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (addr[1:0] == 2'b00) begin
      case (addr[4:2])
        REG_TRIGGER:  trig_len_r = val[TRIG_W-1:0];
        REG_TIMEOUT:  tmo_r = val[TIMEOUT_W-1:0];
        REG_TPC:      tpc_r = val[TPC_W-1:0];
        REG_MAX_DIST: max_cm_r = val[DIST_W-1:0];
        REG_COOLDOWN: cool_r = val[COOL_W-1:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write({idx, 2'b00}, val);
  endtask

  task automatic set_all(input int trig, input int tmo, input int tpc, input int mx, input int cool);
    set_reg(REG_TRIGGER, trig);
    set_reg(REG_TIMEOUT, tmo);
    set_reg(REG_TPC, tpc);
    set_reg(REG_MAX_DIST, mx);
    set_reg(REG_COOLDOWN, cool);
  endtask

  // start, trigger ticks, echo wait, echo pulse, quiet tail
  task automatic queue_measure(input int wait_n, input int high_n, input int tail_n);
    int tlen;
    tlen = (trig_len_r == 0) ? 1 : trig_len_r;
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (tlen - 1) push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    repeat (wait_n) push_tick($urandom_range(0, 3) == 0, 1'b0);
    repeat (high_n) push_tick($urandom_range(0, 3) == 0, 1'b1);
    repeat (tail_n) push_tick(1'b0, 1'b0);
  endtask

  initial begin
    int rand_base;
    int tmo_eff;
    int v;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, then shorten cooldown while it runs
    queue_measure(3, 80, 5);
    drain();
    set_reg(REG_COOLDOWN, 3);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    drain();

    set_all(1, 40, 1, 10, 0);
    queue_measure(0, 5, 1);
    queue_measure(45, 0, 1);
    queue_measure(2, 12, 1);
    queue_measure(1, 50, 2);
    drain();

    // zero timeout expires on the first counted tick
    set_reg(REG_TIMEOUT, 0);
    queue_measure(0, 1, 1);
    queue_measure(1, 0, 1);
    drain();

    // zero trigger length and zero ticks per cm act as one
    set_all(0, 40, 0, 10, 2);
    queue_measure(1, 3, 4);
    drain();
    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    queue_measure(0, 4, 4);
    drain();

    // widest trigger, timeout, ticks per cm and cooldown, then widest max distance
    set_all(255, 32'hFFFF_FFFF, 63, 1000, 65535);
    queue_measure(2, 63 * 3 + 5, 5);
    drain();
    set_all(1, 32'h0001_FFFF, 1, 1023, 0);
    queue_measure(1, 1030, 2);
    drain();

    set_all(2, 30, 3, 8, 2);
    rand_base = ticks_queued;
    while (ticks_queued - rand_base < 900) begin
      if (ticks_queued - rand_base > 750) idle_on = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
          1: v = $urandom_range(0, 80);
          2: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
          3: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 25);
          default: v = $urandom_range(0, 6);
        endcase
        case (v % 1 + $urandom_range(0, 4))
          0: set_reg(REG_TRIGGER, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 4));
          1: set_reg(REG_TIMEOUT, $urandom_range(0, 80));
          2: set_reg(REG_TPC, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 6));
          3: set_reg(REG_MAX_DIST, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(0, 25));
          default: set_reg(REG_COOLDOWN, $urandom_range(0, 6));
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 20))
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        tmo_eff = (tmo_r > TMO_CAP) ? TMO_CAP : tmo_r;
        queue_measure($urandom_range(0, tmo_eff + 1), $urandom_range(1, tmo_eff + 2),
                      cool_r + $urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && range_res_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
